// ===== rtl/core/rpb_pkg.sv =====
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared sizes, request kinds and status codes of the random pick bag.
// ----------------------------------------------------------------------------
`default_nettype none

package rpb_pkg;

  localparam int CAPACITY   = 128;
  localparam int WORD_BITS  = 32;
  localparam int LEVEL_BITS = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RND_BITS   = 15;
  localparam int CNT_BITS   = $clog2(RND_BITS);

  localparam int IN_BITS    = 56;
  localparam int OUT_BITS   = 48;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_PEEK = 2'd1;
  localparam logic [1:0] KIND_POP  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/rpb_ram.sv =====
// ----------------------------------------------------------------------------
// rpb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/random_pick_bag.sv =====
// ----------------------------------------------------------------------------
// random_pick_bag
// Bounded bag of data words with push, random peek and random pop.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel and each gives one result on m_axis.
// A push appends a word unless the bag is full. A peek returns the word at
// slot random_word mod count; a pop returns it, moves the last word into
// that slot and shrinks the count. Full and empty cases report a status and
// leave the bag unchanged. Every result carries the count after the request.
// Push, refused and unused-kind requests go from accept straight to the
// result step; peek and pop first run the restoring remainder (one random
// bit per cycle, 15 bits), then the read and the pop's write-back through
// the single read port of the word memory. One request is in work at a time;
// s_axis_tready is high while the block is idle, even while a finished
// result waits in the output register. A stalled receiver holds the result
// and the next request waits in its final step until the register frees.
// Reset empties the bag at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module random_pick_bag (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // kind[1:0], item_value[33:2], random_word[48:34], zero fill
  input  wire logic [rpb_pkg::IN_BITS-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_value[31:0], status[33:32], fill_count[41:34], zero fill
  output logic      [rpb_pkg::OUT_BITS-1:0] m_axis_tdata
);

  import rpb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_READ, S_FETCH, S_MOVE, S_DONE
  } state_t;

  state_t                state;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] rem;
  logic [RND_BITS-1:0]   rnd_sh;
  logic [CNT_BITS-1:0]   bit_cnt;
  logic                  op_pop;
  logic [31:0]           res_value;
  logic [1:0]            res_status;
  logic [31:0]           m_value;
  logic [1:0]            m_status;
  logic [7:0]            m_count;

  logic [1:0]            in_kind;
  logic [31:0]           in_item;
  logic [RND_BITS-1:0]   in_rnd;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [LEVEL_BITS-1:0] level_m1;
  logic [LEVEL_BITS:0]   rem_sh;
  logic [LEVEL_BITS:0]   rem_diff;
  logic                  rem_ge;
  logic [LEVEL_BITS-1:0] rem_next;
  logic [ADDR_BITS-1:0]  slot;
  logic [63:0]           item_wide;
  logic [63:0]           rd_wide;
  logic [31:0]           rd_word;
  logic [15:0]           level_wide;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  assign in_kind = s_axis_tdata[1:0];
  assign in_item = s_axis_tdata[33:2];
  assign in_rnd  = s_axis_tdata[48:34];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && (state == S_IDLE);

  assign full     = (level >= LEVEL_BITS'(CAPACITY));
  assign empty    = (level == '0);
  assign level_m1 = level - LEVEL_BITS'(1);

  assign rem_sh   = {rem, rnd_sh[RND_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, level};
  assign rem_ge   = (rem_sh >= {1'b0, level});
  assign rem_next = rem_ge ? rem_diff[LEVEL_BITS-1:0] : rem_sh[LEVEL_BITS-1:0];
  assign slot     = rem[ADDR_BITS-1:0];

  assign item_wide  = {32'd0, in_item};
  assign rd_wide    = 64'(ram_rdata);
  assign rd_word    = rd_wide[31:0];
  assign level_wide = 16'(level);

  assign ram_we    = (accept && (in_kind == KIND_PUSH) && !full) || (state == S_MOVE);
  assign ram_waddr = (state == S_MOVE) ? slot : level[ADDR_BITS-1:0];
  assign ram_wdata = (state == S_MOVE) ? ram_rdata : item_wide[WORD_BITS-1:0];
  assign ram_raddr = (state == S_FETCH) ? level_m1[ADDR_BITS-1:0] : slot;

  rpb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      level         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_pop     <= (in_kind == KIND_POP);
            rnd_sh     <= in_rnd;
            rem        <= '0;
            bit_cnt    <= '0;
            res_value  <= '0;
            priority if (in_kind == KIND_PUSH) begin
              state <= S_DONE;
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                level      <= level + LEVEL_BITS'(1);
              end
            end else if (in_kind == KIND_PEEK || in_kind == KIND_POP) begin
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_DIV;
              end
            end else begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          rnd_sh  <= rnd_sh << 1;
          bit_cnt <= bit_cnt + CNT_BITS'(1);
          if (bit_cnt == CNT_BITS'(RND_BITS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          res_value <= rd_word;
          state     <= op_pop ? S_MOVE : S_DONE;
        end
        S_MOVE: begin
          level <= level_m1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_value       <= res_value;
            m_status      <= res_status;
            m_count       <= level_wide[7:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, m_count, m_status, m_value};

endmodule

`default_nettype wire

// ===== rtl/core/rpb_check.sv =====
// ----------------------------------------------------------------------------
// rpb_check
// Port-level checks of the random pick bag, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpb_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [rpb_pkg::IN_BITS-1:0]  s_axis_tdata,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [rpb_pkg::OUT_BITS-1:0] m_axis_tdata
);

  import rpb_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3 &&
      int'(m_axis_tdata[41:34]) <= CAPACITY)
    else $error("bad status or count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == ST_FULL |->
      int'(m_axis_tdata[41:34]) == (CAPACITY % 256))
    else $error("full status with bag not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == ST_EMPTY |->
      m_axis_tdata[41:34] == 8'd0 && m_axis_tdata[31:0] == 32'd0)
    else $error("empty status with words stored");

endmodule

bind random_pick_bag rpb_check u_rpb_check (.*);

`default_nettype wire
